/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the checker files.
// Both expect clk and arst_n to be visible where they are used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property, sampled on the rising edge, idle while in reset
`define AST_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen on a clock edge
`define AST_NEVER(label, cond, msg) `AST_CLK(label, !(cond), msg)

`endif

/* hw/rtl/wipbt_pkg.sv */
package wipbt_pkg;

	localparam int TABLE_ENTRIES = 64;
	localparam int IN_W          = 168;
	localparam int OUT_W         = 32;
	localparam int RES_W         = 29;
	localparam int MIN_W         = 26;

	// floor(x / 15) == (x * MIN_RECIP) >> RECIP_SHIFT for every x below 2**29
	localparam logic [29:0] MIN_RECIP   = 30'd572662307;
	localparam int          RECIP_SHIFT = 33;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CHECK = 1'b1;

	typedef struct packed {
		logic [8:0]  oct_a;
		logic [8:0]  oct_b;
		logic [8:0]  oct_c;
		logic [8:0]  oct_d;
		logic [63:0] serial;
		logic [31:0] start;
		logic [30:0] dur;
		logic        perm;
	} entry_t;

	typedef struct packed {
		logic [8:0]  oct_a;
		logic [8:0]  oct_b;
		logic [8:0]  oct_c;
		logic [8:0]  oct_d;
		logic [63:0] serial;
		logic [31:0] now;
	} probe_t;

	typedef struct packed {
		logic add;
		logic check;
		logic phase;
	} cell_ctl_t;

	typedef struct packed {
		logic        hit;
		logic        kind;
		logic [30:0] rem;
	} tap_t;

	typedef struct packed {
		logic             hit;
		logic             kind;
		logic [MIN_W-1:0] minutes;
	} pick_t;

	typedef struct packed {
		logic             full;
		logic [MIN_W-1:0] minutes;
		logic             kind;
		logic             banned;
	} result_t;

	function automatic logic oct_match(logic [8:0] stored, logic [8:0] probe);
		return stored[8] || (stored == probe);
	endfunction

endpackage

/* hw/rtl/wipbt_cell.sv */
module wipbt_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  wipbt_pkg::cell_ctl_t ctl,
	input  wipbt_pkg::probe_t   probe,
	input  wipbt_pkg::entry_t   new_ent,
	input  logic                odd_pos,
	input  logic                v_left,
	input  logic                v_right,
	input  wipbt_pkg::entry_t   ent_right,
	output logic                valid,
	output wipbt_pkg::entry_t   ent,
	output logic                inv,
	output wipbt_pkg::tap_t     tap
);

	logic              valid_q;
	wipbt_pkg::entry_t ent_q;
	wipbt_pkg::tap_t   tap_s1;

	logic [32:0] diff;
	logic [31:0] elapsed;
	logic        live;
	logic [30:0] rem;
	logic        match_a;
	logic        match_rest;
	logic        hit;
	logic        drop;
	logic        free_here;
	logic        lower;
	logic        take;
	logic        give;

	always_comb begin
		diff       = {1'b0, probe.now} - {1'b0, ent_q.start};
		// clamp to zero when time runs backwards
		elapsed    = diff[32] ? 32'd0 : diff[31:0];
		live       = {1'b0, ent_q.dur} > elapsed;
		rem        = ent_q.dur - elapsed[30:0];
		match_a    = wipbt_pkg::oct_match(ent_q.oct_a, probe.oct_a);
		match_rest = (ent_q.serial == probe.serial) ||
			(wipbt_pkg::oct_match(ent_q.oct_b, probe.oct_b) &&
			 wipbt_pkg::oct_match(ent_q.oct_c, probe.oct_c) &&
			 wipbt_pkg::oct_match(ent_q.oct_d, probe.oct_d));
		hit        = valid_q && match_a && match_rest && live;
		drop       = valid_q && match_a && !ent_q.perm && !live;
		free_here  = !valid_q && v_left;
		// odd-even pairing: this cell is the lower half of its pair this cycle
		lower      = (odd_pos == ctl.phase);
		take       = lower && !valid_q && v_right;
		give       = !lower && !v_left && valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.check && drop) begin
			valid_q <= 1'b0;
		end else if ((ctl.add && free_here) || take) begin
			valid_q <= 1'b1;
		end else if (give) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.add && free_here) begin
			ent_q <= new_ent;
		end else if (take) begin
			ent_q <= ent_right;
		end
		if (ctl.check) begin
			tap_s1.hit  <= hit;
			tap_s1.kind <= ent_q.perm;
			tap_s1.rem  <= rem;
		end
	end

	assign valid = valid_q;
	assign ent   = ent_q;
	assign inv   = !valid_q && v_right;
	assign tap   = tap_s1;

endmodule

/* hw/rtl/wipbt_pick.sv */
module wipbt_pick (
	input  logic            clk,
	input  logic            load,
	input  wipbt_pkg::tap_t taps [wipbt_pkg::TABLE_ENTRIES],
	output wipbt_pkg::pick_t res
);

	logic [wipbt_pkg::TABLE_ENTRIES-1:0] hits;
	logic [wipbt_pkg::TABLE_ENTRIES-1:0] first;
	logic                                kind_c;
	logic [30:0]                         rem_c;

	logic        any_s2;
	logic        kind_s2;
	logic [30:0] rem_s2;
	logic [58:0] prod;

	always_comb begin
		for (int i = 0; i < wipbt_pkg::TABLE_ENTRIES; i++) begin
			hits[i] = taps[i].hit;
		end
		// isolate the lowest set bit: the oldest hit
		first  = hits & (~hits + wipbt_pkg::TABLE_ENTRIES'(1));
		kind_c = 1'b0;
		rem_c  = '0;
		for (int i = 0; i < wipbt_pkg::TABLE_ENTRIES; i++) begin
			kind_c = kind_c | (first[i] & taps[i].kind);
			rem_c  = rem_c | ({31{first[i]}} & taps[i].rem);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			any_s2  <= |hits;
			kind_s2 <= kind_c;
			rem_s2  <= rem_c;
		end
	end

	// rem / 60 == (rem >> 2) / 15
	always_comb begin
		prod        = 59'(rem_s2[30:2]) * 59'(wipbt_pkg::MIN_RECIP);
		res.hit     = any_s2;
		res.kind    = kind_s2;
		res.minutes = prod[wipbt_pkg::RECIP_SHIFT +: wipbt_pkg::MIN_W] +
			wipbt_pkg::MIN_W'(1);
	end

endmodule

/* hw/rtl/wildcard_ip_ban_table_unit.sv */
// Channel | Direction | Payload (lowest bit first)
// s_*     | in        | cmd, octet_a..octet_d, serial_id, ban_kind, duration_s, now_secs
// m_*     | out       | is_banned, matched_kind, minutes_left, table_full
//
// An add item has its result built in state ST_ADD. A check item is worked in order:
// compare in every cell, select the oldest hit, then scale the remaining seconds to minutes.
// After a check that removed entries the cell chain closes the gaps by odd-even swaps between
// neighbours, one position per cycle; the next item waits until the chain is packed again.
// Reset clears every cell's valid bit at once; no clearing pass is needed.
// A finished result may wait in the output register while the next item is accepted and worked.
module wildcard_ip_ban_table_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// cmd[0], octet_a[9:1], octet_b[18:10], octet_c[27:19], octet_d[36:28],
	// serial_id[100:37], ban_kind[101], duration_s[132:102], now_secs[164:133]
	input  logic [wipbt_pkg::IN_W-1:0]  s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// is_banned[0], matched_kind[1], minutes_left[27:2], table_full[28]
	output logic [wipbt_pkg::OUT_W-1:0] m_tdata
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ADD  = 4'b0010,
		ST_SEL  = 4'b0100,
		ST_DIV  = 4'b1000
	} state_t;

	localparam int N = wipbt_pkg::TABLE_ENTRIES;

	state_t state_q;
	state_t state_d;

	logic                  acc;
	logic                  is_check;
	logic                  phase_q;
	logic                  full_q;
	logic                  last_kind_q;
	logic [wipbt_pkg::MIN_W-1:0] last_min_q;

	wipbt_pkg::probe_t     probe;
	wipbt_pkg::entry_t     new_ent;
	wipbt_pkg::cell_ctl_t  ctl;

	logic [N-1:0]          valid;
	logic [N-1:0]          inv;
	wipbt_pkg::entry_t     ents [N];
	wipbt_pkg::tap_t       taps [N];
	wipbt_pkg::pick_t      pick;

	logic                  done;
	wipbt_pkg::result_t    done_res;
	logic                  out_v_q;
	wipbt_pkg::result_t    out_q;
	logic                  pend_v_q;
	wipbt_pkg::result_t    pend_q;

	// Unpack the input item
	always_comb begin
		probe.oct_a     = s_tdata[9:1];
		probe.oct_b     = s_tdata[18:10];
		probe.oct_c     = s_tdata[27:19];
		probe.oct_d     = s_tdata[36:28];
		probe.serial    = s_tdata[100:37];
		probe.now       = s_tdata[164:133];
		new_ent.oct_a   = s_tdata[9:1];
		new_ent.oct_b   = s_tdata[18:10];
		new_ent.oct_c   = s_tdata[27:19];
		new_ent.oct_d   = s_tdata[36:28];
		new_ent.serial  = s_tdata[100:37];
		new_ent.perm    = s_tdata[101];
		new_ent.dur     = s_tdata[132:102];
		new_ent.start   = s_tdata[164:133];
	end

	// Take an item only when idle, the chain is packed and a result slot is free
	assign s_tready  = (state_q == ST_IDLE) && !(|inv) && !pend_v_q;
	assign acc       = s_tvalid && s_tready;
	assign is_check  = (s_tdata[0] == wipbt_pkg::CMD_CHECK);
	assign ctl.add   = acc && !is_check;
	assign ctl.check = acc && is_check;
	assign ctl.phase = phase_q;

	// The cell chain: one entry per cell, oldest at position 0
	for (genvar g = 0; g < N; g++) begin : g_cell
		logic              v_left;
		logic              v_right;
		wipbt_pkg::entry_t ent_right;

		if (g == 0) begin : g_head
			assign v_left = 1'b1;
		end else begin : g_mid
			assign v_left = valid[g-1];
		end
		if (g == N - 1) begin : g_tail
			assign v_right   = 1'b0;
			assign ent_right = ents[g];
		end else begin : g_body
			assign v_right   = valid[g+1];
			assign ent_right = ents[g+1];
		end

		wipbt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.probe     (probe),
			.new_ent   (new_ent),
			.odd_pos   (1'(g % 2)),
			.v_left    (v_left),
			.v_right   (v_right),
			.ent_right (ent_right),
			.valid     (valid[g]),
			.ent       (ents[g]),
			.inv       (inv[g]),
			.tap       (taps[g])
		);
	end

	wipbt_pick u_pick (
		.clk  (clk),
		.load (state_q == ST_SEL),
		.taps (taps),
		.res  (pick)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = is_check ? ST_SEL : ST_ADD;
				end
			end
			ST_ADD:  state_d = ST_IDLE;
			ST_SEL:  state_d = ST_DIV;
			ST_DIV:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= 1'b0;
			last_kind_q <= 1'b0;
			last_min_q  <= '0;
		end else begin
			state_q <= state_d;
			// alternate the pairing so gaps travel up the chain
			phase_q <= !phase_q;
			if ((state_q == ST_DIV) && pick.hit) begin
				last_kind_q <= pick.kind;
				last_min_q  <= pick.minutes;
			end
		end
	end

	// The table is full when the last cell is occupied
	always_ff @(posedge clk) begin
		if (acc) begin
			full_q <= valid[N-1];
		end
	end

	// Build the finished result
	always_comb begin
		done            = (state_q == ST_ADD) || (state_q == ST_DIV);
		done_res.banned = 1'b0;
		done_res.kind   = last_kind_q;
		done_res.minutes = last_min_q;
		done_res.full   = 1'b0;
		if (state_q == ST_ADD) begin
			done_res.full = full_q;
		end else if (pick.hit) begin
			done_res.banned  = 1'b1;
			done_res.kind    = pick.kind;
			done_res.minutes = pick.minutes;
		end
	end

	// Output register with one holding slot behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (pend_v_q) begin
				out_v_q  <= 1'b1;
				pend_v_q <= done;
			end else begin
				out_v_q <= done;
			end
		end else if (done) begin
			pend_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= pend_v_q ? pend_q : done_res;
		end
		if (done) begin
			pend_q <= done_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {(wipbt_pkg::OUT_W - wipbt_pkg::RES_W)'(0), out_q};

endmodule

/* hw/rtl/wipbt_checker.sv */
`include "assert_macros.svh"

module wipbt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       s_tvalid,
	input logic                       s_tready,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [wipbt_pkg::OUT_W-1:0] m_tdata
);

	// a held result stays on offer until taken
	`AST_CLK(a_out_hold, (m_tvalid && !m_tready) |=> m_tvalid, "result dropped before taken")

	// an item never follows another in the very next cycle
	`AST_CLK(a_no_b2b, (s_tvalid && s_tready) |=> !s_tready, "item taken while busy")

	// a result is either a check or an add, never both outcomes
	`AST_NEVER(a_excl, m_tvalid && m_tdata[0] && m_tdata[28], "banned and full together")

	// a hit always reports at least one minute left
	`AST_NEVER(a_min, m_tvalid && m_tdata[0] && (m_tdata[27:2] == 26'd0),
		"hit with zero minutes")

endmodule

bind wildcard_ip_ban_table_unit wipbt_checker u_wipbt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
